// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rce_pkg.sv =====
// ----------------------------------------------------------------------------
// rce_pkg
// Types, codes and the instruction evaluation function of the executor.
// ----------------------------------------------------------------------------
package rce_pkg;

  localparam int MagW = 16;
  localparam int CntW = 5;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_EXEC  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] MODE_IMM  = 2'd0;
  localparam logic [1:0] MODE_DIR  = 2'd1;
  localparam logic [1:0] MODE_IND  = 2'd2;
  localparam logic [1:0] MODE_PDEC = 2'd3;

  localparam logic [7:0] OP_MOV = 8'd1;
  localparam logic [7:0] OP_ADD = 8'd2;
  localparam logic [7:0] OP_SUB = 8'd3;
  localparam logic [7:0] OP_JMP = 8'd4;
  localparam logic [7:0] OP_JMZ = 8'd5;
  localparam logic [7:0] OP_JMN = 8'd6;
  localparam logic [7:0] OP_DJN = 8'd7;
  localparam logic [7:0] OP_CMP = 8'd8;
  localparam logic [7:0] OP_SPL = 8'd9;

  typedef struct packed {
    logic [7:0]  op;
    logic [3:0]  am;
    logic [3:0]  bm;
    logic [15:0] af;
    logic [15:0] bf;
  } cword_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOC, S_WR, S_RD, S_RDW, S_IR, S_IRW, S_EA0, S_EA1,
    S_PR, S_PRW, S_PWB, S_EA2, S_SRC, S_DST, S_EXE0, S_EXE, S_NPC, S_FIN
  } state_t;

  typedef enum logic [2:0] {MA_CLR, MA_LOC, MA_T, MA_EA1, MA_EA2} masel_t;
  typedef enum logic [1:0] {MW_ZERO, MW_ITEM, MW_PTR, MW_EXE} mwsel_t;
  typedef enum logic [1:0] {MS_ADDR, MS_FIELD, MS_IND, MS_NPC} msel_t;

  typedef struct packed {
    logic   mem_we;
    logic   mem_re;
    masel_t mem_asel;
    mwsel_t mem_wsel;
    logic   mod_start;
    msel_t  mod_sel;
    logic   ld_item;
    logic   ld_loc;
    logic   ld_ir;
    logic   ld_t;
    logic   ld_ptr;
    logic   ld_ea;
    logic   ea_loc;
    logic   ld_src;
    logic   ld_dst;
    logic   ld_rdout;
    logic   ld_exe;
    logic   ld_npc;
    logic   out_load;
    logic   clr_inc;
    logic   phase_b;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] mode;
    logic       mod_done;
    logic       mod_busy;
    logic       clr_last;
    logic       died;
    logic       wr;
  } stat_t;

  typedef struct packed {
    logic   died;
    logic   wr;
    logic   jump;
    logic   inc2;
    logic   spl;
    cword_t word;
  } exec_t;

  function automatic exec_t exec_op(input cword_t ir, input cword_t src, input cword_t dst);
    exec_t       e;
    logic        a_only;
    logic [15:0] opnd;
    logic [15:0] nb;
    e      = '0;
    e.word = dst;
    a_only = (ir.am[1:0] == MODE_IMM);
    opnd   = a_only ? src.af : src.bf;
    nb     = dst.bf - 16'd1;
    unique case (ir.op)
      OP_MOV: begin
        e.wr = 1'b1;
        if (a_only) begin
          e.word.bm = src.am;
          e.word.bf = src.af;
        end else begin
          e.word = src;
        end
      end
      OP_ADD: begin
        e.wr      = 1'b1;
        e.word.bf = dst.bf + opnd;
      end
      OP_SUB: begin
        e.wr      = 1'b1;
        e.word.bf = dst.bf - opnd;
      end
      OP_JMP: e.jump = 1'b1;
      OP_JMZ: e.jump = (dst.bf == 16'd0);
      OP_JMN: e.jump = (dst.bf != 16'd0);
      OP_DJN: begin
        e.wr      = 1'b1;
        e.word.bf = nb;
        e.jump    = (nb != 16'd0);
      end
      OP_CMP: e.inc2 = a_only ? (src.af == dst.bf) : (src == dst);
      OP_SPL: e.spl = 1'b1;
      default: e.died = 1'b1;
    endcase
    return e;
  endfunction

endpackage

// ===== sv/rce_mod.sv =====
// ----------------------------------------------------------------------------
// rce_mod
// Iterative true modulo of a 17-bit signed value by the core size.
// ----------------------------------------------------------------------------
module rce_mod #(
  parameter int AW = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [16:0]     value,
  input  logic [AW:0]            cs,
  output logic                   busy,
  output logic                   done,
  output logic [AW-1:0]          rem
);
  import rce_pkg::*;

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [MagW-1:0] mag_r, mag_nxt;
  logic [AW-1:0]   rem_r, rem_nxt;
  logic            neg_r, neg_nxt;
  logic [AW:0]     sh;
  logic [16:0]     absv;

  assign sh   = {rem_r, mag_r[MagW-1]};
  assign absv = value[16] ? 17'(-value) : 17'(value);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(MagW);
      mag_nxt  = absv[MagW-1:0];
      rem_nxt  = '0;
      neg_nxt  = value[16];
    end else if (busy_r && cnt_r != '0) begin
      rem_nxt = (sh >= cs) ? AW'(sh - cs) : AW'(sh);
      mag_nxt = {mag_r[MagW-2:0], 1'b0};
      cnt_nxt = cnt_r - CntW'(1);
    end else if (busy_r) begin
      if (neg_r && rem_r != '0) rem_nxt = AW'(cs - (AW+1)'(rem_r));
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== sv/rce_datapath.sv =====
// ----------------------------------------------------------------------------
// rce_datapath
// Core memory, operand registers, modulo unit and result registers.
// ----------------------------------------------------------------------------
module rce_datapath #(
  parameter int CORE_DEPTH = 4096,
  parameter int TASK_LIMIT = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rce_pkg::cmd_t         cmd,
  output rce_pkg::stat_t        stat,
  input  logic                  cfg_we,
  input  logic [12:0]           cfg_wdata,
  input  logic [1:0]            kind,
  input  logic [11:0]           address,
  input  rce_pkg::cword_t       word,
  input  logic [6:0]            task_count,
  output logic [11:0]           next_pc,
  output logic                  task_died,
  output logic                  spawn_valid,
  output logic [11:0]           spawn_address,
  output logic                  spawn_refused,
  output rce_pkg::cword_t       read_word
);
  import rce_pkg::*;

  localparam int AW = $clog2(CORE_DEPTH);

  cword_t mem [CORE_DEPTH];
  cword_t rdata_r;

  logic [AW:0]   cs_r;
  logic [AW-1:0] clr_r;
  logic [1:0]    kind_r;
  cword_t        item_r;
  logic [6:0]    tc_r;
  logic [AW-1:0] loc_r, t_r, ea1_r, ea2_r;
  cword_t        ir_r, ptr_r, src_r, dst_r;
  logic [11:0]   res_npc_r, res_spa_r;
  logic          res_died_r, res_spv_r, res_spr_r;
  cword_t        res_rd_r;
  logic [11:0]   o_npc_r, o_spa_r;
  logic          o_died_r, o_spv_r, o_spr_r;
  cword_t        o_rd_r;

  logic [1:0]         mode;
  exec_t              ex;
  logic [AW-1:0]      maddr;
  cword_t             mwdata;
  logic signed [16:0] mval;
  logic [15:0]        fld;
  logic               mdone, mbusy;
  logic [AW-1:0]      mrem;
  logic               can_spawn;
  logic [15:0]        ptr_bf;

  assign mode      = cmd.phase_b ? ir_r.bm[1:0] : ir_r.am[1:0];
  assign ex        = exec_op(ir_r, src_r, dst_r);
  assign fld       = cmd.phase_b ? ir_r.bf : ir_r.af;
  assign can_spawn = int'(tc_r) < TASK_LIMIT;
  assign ptr_bf    = (mode == MODE_PDEC) ? rdata_r.bf - 16'd1 : rdata_r.bf;

  always_comb begin
    unique case (cmd.mem_asel)
      MA_CLR:  maddr = clr_r;
      MA_LOC:  maddr = loc_r;
      MA_T:    maddr = t_r;
      MA_EA1:  maddr = ea1_r;
      MA_EA2:  maddr = ea2_r;
      default: maddr = loc_r;
    endcase
    unique case (cmd.mem_wsel)
      MW_ZERO: mwdata = '0;
      MW_ITEM: mwdata = item_r;
      MW_PTR:  mwdata = ptr_r;
      MW_EXE:  mwdata = ex.word;
      default: mwdata = '0;
    endcase
    unique case (cmd.mod_sel)
      MS_ADDR:  mval = $signed(17'(address));
      MS_FIELD: mval = $signed(17'(loc_r)) + $signed({fld[15], fld});
      MS_IND:   mval = $signed(17'(t_r)) + $signed({ptr_r.bf[15], ptr_r.bf});
      MS_NPC:   mval = ex.jump ? $signed(17'(ea1_r))
                               : $signed(17'(loc_r)) + (ex.inc2 ? 17'sd2 : 17'sd1);
      default:  mval = '0;
    endcase
  end

  rce_mod #(.AW(AW)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mod_start),
    .value (mval),
    .cs    (cs_r),
    .busy  (mbusy),
    .done  (mdone),
    .rem   (mrem)
  );

  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[maddr] <= mwdata;
    if (cmd.mem_re) rdata_r <= mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r  <= (AW+1)'((CORE_DEPTH < 4096) ? CORE_DEPTH : 4096);
      clr_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata == 13'd0)              cs_r <= (AW+1)'(1);
        else if (int'(cfg_wdata) > CORE_DEPTH) cs_r <= (AW+1)'(CORE_DEPTH);
        else                                  cs_r <= (AW+1)'(cfg_wdata);
      end
      if (cmd.clr_inc) clr_r <= clr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      kind_r     <= kind;
      item_r     <= word;
      tc_r       <= task_count;
      res_npc_r  <= '0;
      res_spa_r  <= '0;
      res_died_r <= 1'b0;
      res_spv_r  <= 1'b0;
      res_spr_r  <= 1'b0;
      res_rd_r   <= '0;
    end
    if (cmd.ld_loc) loc_r <= mrem;
    if (cmd.ld_ir)  ir_r <= rdata_r;
    if (cmd.ld_t)   t_r <= mrem;
    if (cmd.ld_ptr) ptr_r <= {rdata_r.op, rdata_r.am, rdata_r.bm, rdata_r.af, ptr_bf};
    if (cmd.ld_ea) begin
      if (cmd.phase_b) ea2_r <= cmd.ea_loc ? loc_r : mrem;
      else             ea1_r <= cmd.ea_loc ? loc_r : mrem;
    end
    if (cmd.ld_src)   src_r <= rdata_r;
    if (cmd.ld_dst)   dst_r <= rdata_r;
    if (cmd.ld_rdout) res_rd_r <= rdata_r;
    if (cmd.ld_exe) begin
      res_died_r <= ex.died;
      res_spv_r  <= ex.spl && can_spawn;
      res_spr_r  <= ex.spl && !can_spawn;
      res_spa_r  <= (ex.spl && can_spawn) ? 12'(ea2_r) : 12'd0;
    end
    if (cmd.ld_npc) res_npc_r <= 12'(mrem);
    if (cmd.out_load) begin
      o_npc_r  <= res_npc_r;
      o_spa_r  <= res_spa_r;
      o_died_r <= res_died_r;
      o_spv_r  <= res_spv_r;
      o_spr_r  <= res_spr_r;
      o_rd_r   <= res_rd_r;
    end
  end

  assign stat.kind     = kind_r;
  assign stat.mode     = mode;
  assign stat.mod_done = mdone;
  assign stat.mod_busy = mbusy;
  assign stat.clr_last = (clr_r == AW'(CORE_DEPTH - 1));
  assign stat.died     = ex.died;
  assign stat.wr       = ex.wr;

  assign next_pc       = o_npc_r;
  assign task_died     = o_died_r;
  assign spawn_valid   = o_spv_r;
  assign spawn_address = o_spa_r;
  assign spawn_refused = o_spr_r;
  assign read_word     = o_rd_r;

endmodule

// ===== sv/rce_ctrl.sv =====
// ----------------------------------------------------------------------------
// rce_ctrl
// Sequencer for core clearing, write, read and execute items.
// ----------------------------------------------------------------------------
module rce_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  rce_pkg::stat_t  stat,
  output rce_pkg::cmd_t   cmd
);
  import rce_pkg::*;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   out_free;

  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE: if (in_tvalid) state_nxt = S_LOC;
      S_LOC: begin
        if (stat.mod_done) begin
          unique case (stat.kind)
            KIND_WRITE: state_nxt = S_WR;
            KIND_EXEC:  state_nxt = S_IR;
            KIND_READ:  state_nxt = S_RD;
            default:    state_nxt = S_FIN;
          endcase
        end
      end
      S_WR:  state_nxt = S_FIN;
      S_RD:  state_nxt = S_RDW;
      S_RDW: state_nxt = S_FIN;
      S_IR:  state_nxt = S_IRW;
      S_IRW: state_nxt = S_EA0;
      S_EA0: begin
        if (stat.mode == MODE_IMM) state_nxt = phase_r ? S_SRC : S_IR;
        else                       state_nxt = S_EA1;
      end
      S_EA1: begin
        if (stat.mod_done) begin
          if (stat.mode == MODE_DIR) state_nxt = phase_r ? S_SRC : S_IR;
          else                       state_nxt = S_PR;
        end
      end
      S_PR:  state_nxt = S_PRW;
      S_PRW: state_nxt = S_PWB;
      S_PWB: state_nxt = S_EA2;
      S_EA2: if (stat.mod_done) state_nxt = phase_r ? S_SRC : S_IR;
      S_SRC: state_nxt = S_DST;
      S_DST: state_nxt = S_EXE0;
      S_EXE0: state_nxt = S_EXE;
      S_EXE: state_nxt = stat.died ? S_FIN : S_NPC;
      S_NPC: if (stat.mod_done) state_nxt = S_FIN;
      S_FIN: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mem_asel = MA_LOC;
    cmd.mem_wsel = MW_ZERO;
    cmd.mod_sel  = MS_FIELD;
    cmd.phase_b  = phase_r;
    unique case (state_r)
      S_CLR: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_asel = MA_CLR;
        cmd.clr_inc  = 1'b1;
      end
      S_IDLE: begin
        cmd.ld_item   = in_tvalid;
        cmd.mod_start = in_tvalid;
        cmd.mod_sel   = MS_ADDR;
      end
      S_LOC: cmd.ld_loc = stat.mod_done;
      S_WR: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_wsel = MW_ITEM;
      end
      S_RD:  cmd.mem_re = 1'b1;
      S_RDW: cmd.ld_rdout = 1'b1;
      S_IR:  cmd.mem_re = 1'b1;
      S_IRW: cmd.ld_ir = 1'b1;
      S_EA0: begin
        if (stat.mode == MODE_IMM) begin
          cmd.ld_ea  = 1'b1;
          cmd.ea_loc = 1'b1;
        end else begin
          cmd.mod_start = 1'b1;
        end
      end
      S_EA1: begin
        if (stat.mode == MODE_DIR) cmd.ld_ea = stat.mod_done;
        else                       cmd.ld_t  = stat.mod_done;
      end
      S_PR: begin
        cmd.mem_re   = 1'b1;
        cmd.mem_asel = MA_T;
      end
      S_PRW: cmd.ld_ptr = 1'b1;
      S_PWB: begin
        cmd.mem_we    = (stat.mode == MODE_PDEC);
        cmd.mem_asel  = MA_T;
        cmd.mem_wsel  = MW_PTR;
        cmd.mod_start = 1'b1;
        cmd.mod_sel   = MS_IND;
      end
      S_EA2: cmd.ld_ea = stat.mod_done;
      S_SRC: begin
        cmd.mem_re   = 1'b1;
        cmd.mem_asel = MA_EA1;
      end
      S_DST: begin
        cmd.ld_src   = 1'b1;
        cmd.mem_re   = 1'b1;
        cmd.mem_asel = MA_EA2;
      end
      S_EXE0: cmd.ld_dst = 1'b1;
      S_EXE: begin
        cmd.ld_exe    = 1'b1;
        cmd.mem_we    = !stat.died && stat.wr;
        cmd.mem_asel  = MA_EA2;
        cmd.mem_wsel  = MW_EXE;
        cmd.mod_start = !stat.died;
        cmd.mod_sel   = MS_NPC;
      end
      S_NPC: cmd.ld_npc = stat.mod_done;
      S_FIN: cmd.out_load = out_free;
      default: cmd.mem_asel = MA_LOC;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    if (cmd.ld_item) phase_nxt = 1'b0;
    else if (cmd.ld_ea && !phase_r) phase_nxt = 1'b1;
    ovalid_nxt = ovalid_r;
    if (cmd.out_load) ovalid_nxt = 1'b1;
    else if (out_tready) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      phase_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

endmodule

// ===== sv/redcode_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// redcode_instruction_executor
// Core memory with write, read and single-instruction execute items.
// ----------------------------------------------------------------------------
// Input beats carry the item kind on in_tuser and the address, word and task
// count on in_tdata; each beat yields exactly one output beat. cfg_we with
// cfg_wdata sets the core size; the user must write it only while the block
// is idle, as the block itself does not enforce this. Every address reduction
// runs through one shift-subtract modulo unit. An execute item takes up to
// six modulo passes plus the single-port core memory reads and writes in
// sequence. One item is in work at a time: a new beat is taken only once the
// previous item is finished and the sequencer is back in idle.
// After reset the core is cleared to DAT 0,0 one word a cycle, all CORE_DEPTH
// words, with in_tready low. A finished result sits in an output register;
// the next item is accepted and worked on while it waits, and that item's
// result is held back until the receiver takes the earlier one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module redcode_instruction_executor #(
  parameter int CORE_DEPTH = 4096,
  parameter int TASK_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,   // core_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,    // address, word_opcode, word_a_mode, word_b_mode,
                                   // word_a_field, word_b_field, task_count
  input  logic [1:0]  in_tuser,    // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata    // next_pc, task_died, spawn_valid, spawn_address,
                                   // spawn_refused, read_opcode, read_a_mode,
                                   // read_b_mode, read_a_field, read_b_field
);
  import rce_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  cword_t      in_word, rd_word;
  logic [11:0] next_pc, spawn_address;
  logic        task_died, spawn_valid, spawn_refused;

  assign in_word.op = in_tdata[19:12];
  assign in_word.am = in_tdata[23:20];
  assign in_word.bm = in_tdata[27:24];
  assign in_word.af = in_tdata[43:28];
  assign in_word.bf = in_tdata[59:44];

  rce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rce_datapath #(
    .CORE_DEPTH (CORE_DEPTH),
    .TASK_LIMIT (TASK_LIMIT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .kind          (in_tuser),
    .address       (in_tdata[11:0]),
    .word          (in_word),
    .task_count    (in_tdata[66:60]),
    .next_pc       (next_pc),
    .task_died     (task_died),
    .spawn_valid   (spawn_valid),
    .spawn_address (spawn_address),
    .spawn_refused (spawn_refused),
    .read_word     (rd_word)
  );

  assign out_tdata = {5'd0, rd_word.bf, rd_word.af, rd_word.bm, rd_word.am, rd_word.op,
                      spawn_refused, spawn_address, spawn_valid, task_died, next_pc};

  `ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "second item accepted")
  `ASSERT_NOW(a_mod_not_busy, cmd.mod_start, !stat.mod_busy, "modulo restarted while busy")
  `ASSERT_NOW(a_single_port, cmd.mem_we, !cmd.mem_re, "core read and write in one cycle")
  `ASSERT_NOW(a_dead_clean, out_tvalid && out_tdata[12],
              out_tdata[11:0] == 12'd0 && !out_tdata[13], "dead task with pc or spawn")

endmodule
